// File: rtl/slin_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slin_pkg: shared types and constants of the scancode line input unit
// Holds the action codes, the scancode constants, the set-1 key map and the
// structs that pass between the step logic and the top level.
// ----------------------------------------------------------------------------
package slin_pkg;

   localparam int unsigned CodeWidth = 8;
   localparam int unsigned CharWidth = 7;
   localparam int unsigned LenWidth  = 8;

   localparam logic [LenWidth-1:0] MaxLineReset = 8'd199;

   // scancodes
   localparam logic [CodeWidth-1:0] CodeCtrlMake  = 8'h1D;
   localparam logic [CodeWidth-1:0] CodeCtrlBreak = 8'h9D;
   localparam logic [CodeWidth-1:0] CodeKeyS      = 8'd31;
   localparam logic [CodeWidth-1:0] CodeKeyX      = 8'd45;
   localparam logic [CodeWidth-1:0] KeymapSize    = 8'd58;

   // characters
   localparam logic [CharWidth-1:0] CharNone  = 7'd0;
   localparam logic [CharWidth-1:0] CharCtrlS = 7'd1;
   localparam logic [CharWidth-1:0] CharCtrlX = 7'd2;
   localparam logic [CharWidth-1:0] CharBs    = 7'd8;
   localparam logic [CharWidth-1:0] CharLf    = 7'd10;

   typedef enum logic [2:0] {
      ACT_IGNORE = 3'd0,
      ACT_APPEND = 3'd1,
      ACT_REMOVE = 3'd2,
      ACT_ENTER  = 3'd3,
      ACT_CTRL_S = 3'd4,
      ACT_CTRL_X = 3'd5
   } action_type;

   typedef struct packed {
      logic                ctrl_held;
      logic [LenWidth-1:0] line_count;
   } state_type;

   typedef struct packed {
      action_type           action;
      logic [CharWidth-1:0] character;
      logic [LenWidth-1:0]  line_length;
   } result_type;

   // set-1 make code to ascii, zero where no key maps
   function automatic logic [CharWidth-1:0] keymap_lookup(input logic [CodeWidth-1:0] code);
      logic [CharWidth-1:0] ch;
      ch = CharNone;
      unique case (code)
         8'd2:    ch = 7'h31;
         8'd3:    ch = 7'h32;
         8'd4:    ch = 7'h33;
         8'd5:    ch = 7'h34;
         8'd6:    ch = 7'h35;
         8'd7:    ch = 7'h36;
         8'd8:    ch = 7'h37;
         8'd9:    ch = 7'h38;
         8'd10:   ch = 7'h39;
         8'd11:   ch = 7'h30;
         8'd12:   ch = 7'h2D;
         8'd13:   ch = 7'h3D;
         8'd14:   ch = CharBs;
         8'd16:   ch = 7'h71;
         8'd17:   ch = 7'h77;
         8'd18:   ch = 7'h65;
         8'd19:   ch = 7'h72;
         8'd20:   ch = 7'h74;
         8'd21:   ch = 7'h79;
         8'd22:   ch = 7'h75;
         8'd23:   ch = 7'h69;
         8'd24:   ch = 7'h6F;
         8'd25:   ch = 7'h70;
         8'd26:   ch = 7'h5B;
         8'd27:   ch = 7'h5D;
         8'd28:   ch = CharLf;
         8'd30:   ch = 7'h61;
         8'd31:   ch = 7'h73;
         8'd32:   ch = 7'h64;
         8'd33:   ch = 7'h66;
         8'd34:   ch = 7'h67;
         8'd35:   ch = 7'h68;
         8'd36:   ch = 7'h6A;
         8'd37:   ch = 7'h6B;
         8'd38:   ch = 7'h6C;
         8'd39:   ch = 7'h3B;
         8'd40:   ch = 7'h27;
         8'd41:   ch = 7'h60;
         8'd44:   ch = 7'h7A;
         8'd45:   ch = 7'h78;
         8'd46:   ch = 7'h63;
         8'd47:   ch = 7'h76;
         8'd48:   ch = 7'h62;
         8'd49:   ch = 7'h6E;
         8'd50:   ch = 7'h6D;
         8'd51:   ch = 7'h2C;
         8'd52:   ch = 7'h2E;
         8'd53:   ch = 7'h2F;
         8'd54:   ch = 7'h2E;
         8'd55:   ch = 7'h2F;
         8'd57:   ch = 7'h20;
         default: ch = CharNone;
      endcase
      return ch;
   endfunction

endpackage

// File: rtl/slin_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slin_if: channel interfaces of the scancode line input unit
// Scancode request, action response and the max line length register write.
// ----------------------------------------------------------------------------
interface slin_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] scan_code;

   modport source (output valid, output scan_code, input ready);
   modport sink   (input valid, input scan_code, output ready);
endinterface

interface slin_rsp_if;
   logic                  valid;
   logic                  ready;
   slin_pkg::action_type  action;
   logic [6:0]            character;
   logic [7:0]            line_length;

   modport source (output valid, output action, output character, output line_length,
                   input ready);
   modport sink   (input valid, input action, input character, input line_length,
                   output ready);
endinterface

interface slin_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/slin_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slin_step: per-scancode line edit decision
// Maps one scancode and the current ctrl / length state to an action and the
// next state.
// ----------------------------------------------------------------------------
module slin_step (
   input  logic [7:0]             scan_code,
   input  logic [7:0]             max_line_chars,
   input  slin_pkg::state_type    state,
   output slin_pkg::state_type    state_nxt,
   output slin_pkg::result_type   result
);
   import slin_pkg::*;

   logic [CharWidth-1:0] ch;

   assign ch = (scan_code < KeymapSize) ? keymap_lookup(scan_code) : CharNone;

   always_comb begin
      state_nxt          = state;
      result.action      = ACT_IGNORE;
      result.character   = CharNone;
      result.line_length = state.line_count;

      priority if (scan_code[7]) begin
         // break codes, also the extended prefix
         if (scan_code == CodeCtrlBreak) begin
            state_nxt.ctrl_held = 1'b0;
         end
      end else if (scan_code == CodeCtrlMake) begin
         state_nxt.ctrl_held = 1'b1;
      end else if (state.ctrl_held) begin
         if (scan_code == CodeKeyS) begin
            result.action    = ACT_CTRL_S;
            result.character = CharCtrlS;
            state_nxt        = '0;
         end else if (scan_code == CodeKeyX) begin
            result.action    = ACT_CTRL_X;
            result.character = CharCtrlX;
            state_nxt        = '0;
         end
      end else if (ch == CharLf) begin
         result.action    = ACT_ENTER;
         result.character = CharLf;
         state_nxt        = '0;
      end else if (ch == CharBs) begin
         if (state.line_count != '0) begin
            state_nxt.line_count = state.line_count - 8'd1;
            result.action        = ACT_REMOVE;
            result.character     = CharBs;
            result.line_length   = state.line_count - 8'd1;
         end
      end else if (ch != CharNone && state.line_count < max_line_chars) begin
         state_nxt.line_count = state.line_count + 8'd1;
         result.action        = ACT_APPEND;
         result.character     = ch;
         result.line_length   = state.line_count + 8'd1;
      end else begin
         // unmapped key or full line, ignored with the defaults above
         state_nxt = state;
      end
   end

endmodule

// File: rtl/scancode_line_input_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_line_input_unit: set-1 scancode line editor
// Tracks ctrl and the typed line length and reports one edit action for each
// scancode, so a consumer can rebuild the line.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                              role
//  req_chan  in         scan_code                            one scancode byte
//  rsp_chan  out        action, character, line_length       one action per byte
//  csr_chan  in         data                                 max_line_chars write
//
//  one transaction per cycle sustained while rsp_chan is ready; a scancode is
//  held in the input register, then its action lands in the output register,
//  with the decode and state update between those registers combinational
//  reset: ctrl released, line empty, max_line_chars 199, both stages empty
//  a stalled response holds the output register; the input register keeps
//  its scancode and the request side stalls only once both are full
//
module scancode_line_input_unit (
   input logic        clock,
   input logic        reset,
   slin_req_if.sink   req_chan,
   slin_rsp_if.source rsp_chan,
   slin_csr_if.sink   csr_chan
);
   import slin_pkg::*;

   // configuration
   logic [LenWidth-1:0] max_line_ff;
   logic [LenWidth-1:0] max_line_in;

   // input stage
   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [CodeWidth-1:0] in_code_ff;
   logic [CodeWidth-1:0] in_code_in;

   // line state
   state_type state_ff;
   state_type state_in;
   state_type state_step;

   // output stage
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_res_ff;
   result_type out_res_in;
   result_type res_step;

   logic req_take;
   logic advance;

   // decode for the scancode sitting in the input register
   slin_step u_step (
      .scan_code      (in_code_ff),
      .max_line_chars (max_line_ff),
      .state          (state_ff),
      .state_nxt      (state_step),
      .result         (res_step)
   );

   // input stage moves on when the output register is free or being drained
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      max_line_in  = (csr_chan.valid) ? csr_chan.data : max_line_ff;

      in_valid_in  = req_take || (in_valid_ff && !advance);
      in_code_in   = (req_take) ? req_chan.scan_code : in_code_ff;

      // state only changes when an item hands its action on
      state_in     = (advance) ? state_step : state_ff;

      out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
      out_res_in   = (advance) ? res_step : out_res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_line_ff  <= MaxLineReset;
         in_valid_ff  <= 1'b0;
         state_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         max_line_ff  <= max_line_in;
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_code_ff <= in_code_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.action      = out_res_ff.action;
   assign rsp_chan.character   = out_res_ff.character;
   assign rsp_chan.line_length = out_res_ff.line_length;

endmodule
